>>> hdl/csr_pkg.sv
// Shared types, codes and constants of the compressed sparse row adjacency block.
package csr_pkg;

    // Default sizes of the row table and of the neighbor store.
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 16384;

    // Fixed field widths.
    localparam int ACT_W      = 2;
    localparam int VERT_W     = 10;
    localparam int COL_W      = 10;
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 1;
    localparam int STAT_W     = 3;
    localparam int CNT_W      = 15;
    localparam int ROWS_W     = 11;
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 64;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_VERTICES = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_COLUMNS  = 1'b1;

    // Item kinds; the fourth code changes no state but still gets a result.
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLOSE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_ROW_ORDER = 3'd1,
        ST_ROW_RANGE = 3'd2,
        ST_COL_RANGE = 3'd3,
        ST_FULL      = 3'd4,
        ST_NOT_BUILT = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RS_BEGIN,
        S_RS_END,
        S_SCAN,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;        // capture the accepted item
        logic exec;        // capture the check result
        logic append;      // store the column, advance the fill pointer
        logic close;       // seal the current row
        logic rs_rd;       // read the row start table
        logic rs_rd_next;  // read at vertex + 1 instead of vertex
        logic take_begin;  // load the scan pointer from the table
        logic take_end;    // load the scan end from the table
        logic scan_step;   // one step of the slice scan
        logic load_out;    // load the result register
    } t_csr_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        t_status          chk;
        logic             scan_done;
        logic             out_free;
    } t_csr_sts;

endpackage

>>> hdl/csr_ctrl.sv
// Controller state machine that sequences item checks, updates and row scans.
module csr_ctrl
    import csr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_item_valid,
    output logic     o_item_ready,
    input  t_csr_sts i_sts,
    output t_csr_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.action == ACT_QUERY && i_sts.chk == ST_OK) n_state = S_RS_BEGIN;
                else n_state = S_DONE;
            end
            S_RS_BEGIN: n_state = S_RS_END;
            S_RS_END:   n_state = S_SCAN;
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_item_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_item_ready = 1'b1;
                o_cmd.take   = i_item_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_sts.action)
                    ACT_ADD:   o_cmd.append = (i_sts.chk == ST_OK);
                    ACT_CLOSE: o_cmd.close  = (i_sts.chk == ST_OK);
                    ACT_QUERY: o_cmd.rs_rd  = (i_sts.chk == ST_OK);
                    default:   o_cmd.exec   = 1'b1;
                endcase
            end
            S_RS_BEGIN: begin
                o_cmd.take_begin = 1'b1;
                o_cmd.rs_rd      = 1'b1;
                o_cmd.rs_rd_next = 1'b1;
            end
            S_RS_END: o_cmd.take_end  = 1'b1;
            S_SCAN:   o_cmd.scan_step = 1'b1;
            S_DONE:   o_cmd.load_out  = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

>>> hdl/csr_dp.sv
// Datapath: configuration, row start table, neighbor store, statistics and result register.
module csr_dp
    import csr_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_csr_cmd              i_cmd,
    output t_csr_sts              o_sts,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [VERT_W-1:0]     i_vertex,
    input  logic [COL_W-1:0]      i_column,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_m_ready,
    output logic                  o_m_valid,
    output logic [STAT_W-1:0]     o_status,
    output logic                  o_found,
    output logic [CNT_W-1:0]      o_edge_count,
    output logic [CNT_W-1:0]      o_max_degree,
    output logic [CNT_W-1:0]      o_min_degree,
    output logic [ROWS_W-1:0]     o_rows_built
);

    localparam int PW       = $clog2(MAX_EDGES + 1);
    localparam int EW       = $clog2(MAX_EDGES);
    localparam int RS_DEPTH = MAX_VERTICES + 1;
    localparam int RSW      = $clog2(RS_DEPTH);

    logic [CFG_W-1:0]  r_num_vertices;
    logic [CFG_W-1:0]  r_num_columns;
    logic [ACT_W-1:0]  r_act;
    logic [VERT_W-1:0] r_v;
    logic [COL_W-1:0]  r_c;

    logic [ROWS_W-1:0] r_next_row;
    logic [PW-1:0]     r_fill;
    logic [PW-1:0]     r_cur_start;
    logic [PW-1:0]     r_total;
    logic [PW-1:0]     r_largest;
    logic [PW-1:0]     r_smallest;

    logic [PW-1:0]     r_rs_mem [RS_DEPTH];
    logic [PW-1:0]     r_rs_q;
    logic [COL_W-1:0]  r_nb_mem [MAX_EDGES];
    logic [COL_W-1:0]  r_nb_q;

    logic [PW-1:0]     r_p;
    logic [PW-1:0]     r_e;
    logic              r_pend;
    t_status           r_status;
    logic              r_found;

    logic              r_m_valid;
    t_status           r_o_status;
    logic              r_o_found;
    logic [CNT_W-1:0]  r_o_edge;
    logic [CNT_W-1:0]  r_o_max;
    logic [CNT_W-1:0]  r_o_min;
    logic [ROWS_W-1:0] r_o_rows;

    logic              v_out_range;
    logic              v_order;
    logic              store_full;
    t_status           chk;
    logic [PW-1:0]     deg;
    logic [RSW-1:0]    rs_waddr;
    logic [RSW-1:0]    rs_raddr;
    logic              p_lt_e;
    logic              hit;
    logic              nb_rd;
    logic [31:0]       total_ext;
    logic [31:0]       largest_ext;
    logic [31:0]       smallest_ext;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vertices <= '0;
            r_num_columns  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_NUM_VERTICES: r_num_vertices <= i_cfg_data;
                CFG_NUM_COLUMNS:  r_num_columns  <= i_cfg_data;
                default:          r_num_columns  <= r_num_columns;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_act <= i_action;
            r_v   <= i_vertex;
            r_c   <= i_column;
        end
    end

    // Item checks, in the order the status codes take precedence.
    assign v_out_range = (32'(r_v) >= 32'(r_num_vertices)) || (32'(r_v) >= MAX_VERTICES);
    assign v_order     = ({1'b0, r_v} != r_next_row);
    assign store_full  = (32'(r_fill) >= MAX_EDGES);

    always_comb begin
        chk = ST_OK;
        case (r_act)
            ACT_ADD: begin
                if (v_order) chk = ST_ROW_ORDER;
                else if (v_out_range) chk = ST_ROW_RANGE;
                else if (store_full) chk = ST_FULL;
            end
            ACT_CLOSE: begin
                if (v_order) chk = ST_ROW_ORDER;
                else if (v_out_range) chk = ST_ROW_RANGE;
            end
            ACT_QUERY: begin
                if (v_out_range) chk = ST_ROW_RANGE;
                else if ({1'b0, r_c} >= r_num_columns) chk = ST_COL_RANGE;
                else if ({1'b0, r_v} >= r_next_row) chk = ST_NOT_BUILT;
            end
            default: chk = ST_OK;
        endcase
    end

    // Build state: fill pointer, current row start and degree statistics.
    assign deg = r_fill - r_cur_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_row  <= '0;
            r_fill      <= '0;
            r_cur_start <= '0;
            r_total     <= '0;
            r_largest   <= '0;
            r_smallest  <= PW'(MAX_EDGES);
        end else begin
            if (i_cmd.append) r_fill <= r_fill + 1'b1;
            if (i_cmd.close) begin
                r_cur_start <= r_fill;
                r_total     <= r_total + deg;
                r_next_row  <= r_next_row + 1'b1;
                if (deg > r_largest) r_largest <= deg;
                if (deg < r_smallest) r_smallest <= deg;
            end
        end
    end

    // Row start table; entry zero is never written and is read as zero.
    assign rs_waddr = RSW'(32'(r_v) + 1);
    assign rs_raddr = i_cmd.rs_rd_next ? rs_waddr : RSW'(r_v);

    always_ff @(posedge i_clk) begin
        if (i_cmd.close) r_rs_mem[rs_waddr] <= r_fill;
        if (i_cmd.rs_rd) r_rs_q <= r_rs_mem[rs_raddr];
    end

    // Neighbor store with registered read for the scan.
    assign p_lt_e = (r_p < r_e);
    assign nb_rd  = i_cmd.scan_step && p_lt_e;
    assign hit    = r_pend && (r_nb_q == r_c);

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) r_nb_mem[EW'(r_fill)] <= r_c;
        if (nb_rd) r_nb_q <= r_nb_mem[EW'(r_p)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_begin) r_p <= (r_v == '0) ? '0 : r_rs_q;
        else if (nb_rd) r_p <= r_p + 1'b1;
        if (i_cmd.take_end) r_e <= r_rs_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_cmd.take_end) begin
            r_pend <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_pend <= p_lt_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= chk;
            r_found  <= 1'b0;
        end else if (i_cmd.scan_step && hit) begin
            r_found  <= 1'b1;
        end
    end

    // Result register.
    assign total_ext    = 32'(r_total);
    assign largest_ext  = 32'(r_largest);
    assign smallest_ext = 32'(r_smallest);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_edge   <= total_ext[CNT_W-1:0];
            r_o_max    <= largest_ext[CNT_W-1:0];
            r_o_min    <= smallest_ext[CNT_W-1:0];
            r_o_rows   <= r_next_row;
        end
    end

    assign o_sts.action    = r_act;
    assign o_sts.chk       = chk;
    assign o_sts.scan_done = hit || (!r_pend && !p_lt_e);
    assign o_sts.out_free  = !r_m_valid || i_m_ready;

    assign o_m_valid    = r_m_valid;
    assign o_status     = r_o_status;
    assign o_found      = r_o_found;
    assign o_edge_count = r_o_edge;
    assign o_max_degree = r_o_max;
    assign o_min_degree = r_o_min;
    assign o_rows_built = r_o_rows;

endmodule

>>> hdl/csr_adjacency_build_and_query.sv
// Top level of the compressed sparse row adjacency builder and membership query block.
//
//  Channel   Direction  Handshake                    Payload
//  -------   ---------  ---------------------------  ---------------------------------------
//  s_axis    in         i_s_tvalid / o_s_tready      tuser: action; tdata: vertex, column
//  m_axis    out        o_m_tvalid / i_m_tready      tdata: status, found, edge_count,
//                                                    max_degree, min_degree, rows_built
//  cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_addr: register, i_cfg_data: value
//
// An add, a close, an unused item kind or a query that fails its checks goes from its
// transfer through the check state to the done state, where its result is loaded once the
// output register is free, and the next item is taken back in idle. A query that passes
// its checks reads the row start table at the vertex and at vertex + 1, then scans the row
// slice through the neighbor store's single registered read port, one entry per cycle,
// until the column is found or the slice ends; an empty row ends the scan at once.
// The block works on one item at a time.
// Reset is synchronous and active low; it clears the build state and the statistics, and
// the row start table and the neighbor store need no clearing pass since only written
// entries are ever read. A stalled result waits in the output register; the next item
// is taken while it waits, and the block holds in its final state only if a second
// result is ready before the first one has been taken.
module csr_adjacency_build_and_query
    import csr_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input items.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // vertex[9:0], column[19:10], zero[23:20]
    input  logic [S_TUSER_W-1:0]  i_s_tuser,   // action[1:0]
    // Result items.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // status[2:0], found[3], edge_count[18:4],
                                               // max_degree[33:19], min_degree[48:34],
                                               // rows_built[59:49], zero[63:60]
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_csr_cmd          cmd;
    t_csr_sts          sts;
    logic              cfg_we;
    logic [STAT_W-1:0] res_status;
    logic              res_found;
    logic [CNT_W-1:0]  res_edge_count;
    logic [CNT_W-1:0]  res_max_degree;
    logic [CNT_W-1:0]  res_min_degree;
    logic [ROWS_W-1:0] res_rows_built;

    // Always ready; the user must send config writes only while the block is idle.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    csr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_s_tvalid),
        .o_item_ready (o_s_tready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    csr_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_action     (i_s_tuser[ACT_W-1:0]),
        .i_vertex     (i_s_tdata[VERT_W-1:0]),
        .i_column     (i_s_tdata[VERT_W+COL_W-1:VERT_W]),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_m_ready    (i_m_tready),
        .o_m_valid    (o_m_tvalid),
        .o_status     (res_status),
        .o_found      (res_found),
        .o_edge_count (res_edge_count),
        .o_max_degree (res_max_degree),
        .o_min_degree (res_min_degree),
        .o_rows_built (res_rows_built)
    );

    // Result fields packed from the lowest bit up, padded to whole bytes.
    assign o_m_tdata = {4'b0000, res_rows_built, res_min_degree, res_max_degree,
                        res_edge_count, res_found, res_status};

endmodule

>>> test/testbench.sv
// Self-checking testbench for the compressed sparse row adjacency build and query block.
`timescale 1ns / 1ps

module testbench
    import csr_pkg::*;
();

    localparam int MAX_V = DEF_MAX_VERTICES;
    localparam int MAX_E = DEF_MAX_EDGES;

    // The fourth item kind is not listed in the package; the block changes no state for it but still returns a result.
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    // One result as the block reports it, fields in the order of the tdata packing.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [CNT_W-1:0]  edge_count;
        logic [CNT_W-1:0]  max_degree;
        logic [CNT_W-1:0]  min_degree;
        logic [ROWS_W-1:0] rows_built;
    } t_adj_answer;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic [S_TUSER_W-1:0]  i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_W-1:0]      i_cfg_data  = '0;

    csr_adjacency_build_and_query dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs somewhere.
    initial begin
        #20_000_000;
        $display("csr_adjacency_build_and_query test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the row table, the neighbor store,
    // the build counters and the two limit registers.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  row_start_tbl [0:MAX_V];
    logic [COL_W-1:0]  column_store  [0:MAX_E-1];
    logic [ROWS_W-1:0] rows_closed  = '0;
    logic [CNT_W-1:0]  fill_ptr     = '0;
    logic [CNT_W-1:0]  edges_total  = '0;
    logic [CNT_W-1:0]  deg_max      = '0;
    logic [CNT_W-1:0]  deg_min      = CNT_W'(MAX_E);
    logic [CFG_W-1:0]  lim_vertices = '0;
    logic [CFG_W-1:0]  lim_columns  = '0;

    t_adj_answer adjacency_answers_due [$];
    int          error_count = 0;

    // Sender bookkeeping: remaining items of the current burst and whether
    // tvalid is currently held high.
    int burst_left  = 0;
    bit s_offering  = 1'b0;
    // Adds still to go for the row being built by the random traffic, -1 if none.
    int build_left  = -1;
    // Cycles of forced back-pressure still to apply on the result channel.
    int rx_hold_left = 0;

    function automatic logic [STAT_W-1:0] build_status(input int unsigned vtx,
                                                       input int unsigned limit);
        if (vtx != rows_closed)
            return ST_ROW_ORDER;
        if (vtx >= limit)
            return ST_ROW_RANGE;
        return ST_OK;
    endfunction

    // Advances the predictor by one item and returns the answer it must produce.
    function automatic t_adj_answer predict_adjacency_answer(input logic [ACT_W-1:0]  act,
                                                             input logic [VERT_W-1:0] vtx,
                                                             input logic [COL_W-1:0]  col);
        t_adj_answer      ans;
        int unsigned      limit;
        int unsigned      v;
        int unsigned      p;
        logic [CNT_W-1:0] deg;
        ans   = '0;
        v     = vtx;
        limit = (lim_vertices < MAX_V) ? lim_vertices : MAX_V;
        case (act)
            ACT_ADD: begin
                ans.status = build_status(v, limit);
                if (ans.status == ST_OK) begin
                    if (fill_ptr >= MAX_E) begin
                        ans.status = ST_FULL;
                    end else begin
                        column_store[fill_ptr] = col;
                        fill_ptr++;
                    end
                end
            end
            ACT_CLOSE: begin
                ans.status = build_status(v, limit);
                if (ans.status == ST_OK) begin
                    deg              = fill_ptr - row_start_tbl[v];
                    row_start_tbl[v+1] = fill_ptr;
                    edges_total      = edges_total + deg;
                    if (deg > deg_max)
                        deg_max = deg;
                    if (deg < deg_min)
                        deg_min = deg;
                    rows_closed++;
                end
            end
            ACT_QUERY: begin
                if (v >= limit) begin
                    ans.status = ST_ROW_RANGE;
                end else if (col >= lim_columns) begin
                    ans.status = ST_COL_RANGE;
                end else if (v >= rows_closed) begin
                    ans.status = ST_NOT_BUILT;
                end else begin
                    for (p = row_start_tbl[v]; p < row_start_tbl[v+1] && p < MAX_E; p++) begin
                        if (column_store[p] == col) begin
                            ans.found = 1'b1;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        ans.edge_count = edges_total;
        ans.max_degree = deg_max;
        ans.min_degree = deg_min;
        ans.rows_built = rows_closed;
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Result side: back-pressure pattern and the checker.
    // ------------------------------------------------------------------
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int rx_tick      = 0;

    // The receiver switches between always ready, random stalls and a fixed
    // stall pattern, each for a random stretch; a requested hold overrides it.
    always @(posedge i_clk) begin
        rx_tick++;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= ($urandom_range(0, 2) != 0);
                default: i_m_tready <= ((rx_tick % 5) >= 2);
            endcase
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            error_count++;
            if (error_count <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Values read right after the edge are the ones the transfer carried.
    always @(posedge i_clk) begin : answer_check
        t_adj_answer want;
        t_adj_answer got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status     = o_m_tdata[2:0];
            got.found      = o_m_tdata[3];
            got.edge_count = o_m_tdata[18:4];
            got.max_degree = o_m_tdata[33:19];
            got.min_degree = o_m_tdata[48:34];
            got.rows_built = o_m_tdata[59:49];
            if (adjacency_answers_due.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result transfer with nothing expected, tdata %h",
                             $time, o_m_tdata);
            end else begin
                want = adjacency_answers_due.pop_front();
                check_field("status",     want.status,     got.status);
                check_field("found",      want.found,      got.found);
                check_field("edge_count", want.edge_count, got.edge_count);
                check_field("max_degree", want.max_degree, got.max_degree);
                check_field("min_degree", want.min_degree, got.min_degree);
                check_field("rows_built", want.rows_built, got.rows_built);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------

    // Offers one item, waits for its transfer and records the predicted answer.
    // tvalid stays high afterwards so that the next item can follow without a gap.
    task automatic send_item(input logic [ACT_W-1:0]  act,
                             input logic [VERT_W-1:0] vtx,
                             input logic [COL_W-1:0]  col);
        int gap;
        if (burst_left == 0) begin
            // Mostly short bursts, now and then a long one with no idling at all.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                if (s_offering)
                    i_s_tvalid <= 1'b0;
                s_offering = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {4'b0000, col, vtx};
        s_offering = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        adjacency_answers_due.insert(adjacency_answers_due.size(),
                                     predict_adjacency_answer(act, vtx, col));
    endtask

    // Stops offering and waits until every expected result has been taken.
    task automatic wait_results_drained();
        if (s_offering)
            i_s_tvalid <= 1'b0;
        s_offering = 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (adjacency_answers_due.size() != 0);
    endtask

    // Writes both limit registers back to back; only called while the block is idle.
    task automatic write_config(input int unsigned vertices, input int unsigned columns);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= CFG_NUM_VERTICES;
        i_cfg_data  <= CFG_W'(vertices);
        do @(posedge i_clk); while (!o_cfg_ready);
        lim_vertices = CFG_W'(vertices);
        i_cfg_addr  <= CFG_NUM_COLUMNS;
        i_cfg_data  <= CFG_W'(columns);
        do @(posedge i_clk); while (!o_cfg_ready);
        lim_columns = CFG_W'(columns);
        i_cfg_valid <= 1'b0;
    endtask

    // One item of random traffic. Most items are well-formed row builds and
    // queries aimed at closed rows; the rest are out-of-order builds, queries
    // at random places and items of the unused kind.
    task automatic send_random_item(output bit counted);
        int               pick;
        int unsigned      v;
        int unsigned      p;
        logic [COL_W-1:0] col;
        pick    = $urandom_range(0, 99);
        counted = 1'b1;
        col     = $urandom_range(0, 1023);
        if (pick < 45) begin
            if (build_left < 0)
                build_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                          : $urandom_range(0, 10);
            if (build_left > 0) begin
                build_left--;
                send_item(ACT_ADD, VERT_W'(rows_closed), col);
            end else begin
                build_left = -1;
                send_item(ACT_CLOSE, VERT_W'(rows_closed), col);
            end
        end else if (pick < 80) begin
            if (rows_closed > 0 && $urandom_range(0, 2) != 0) begin
                v = $urandom_range(0, rows_closed - 1);
                // Half of these look for a column that is really in the row.
                if (row_start_tbl[v+1] > row_start_tbl[v] && $urandom_range(0, 1)) begin
                    p   = $urandom_range(row_start_tbl[v], row_start_tbl[v+1] - 1);
                    col = column_store[p];
                end
            end else begin
                v = $urandom_range(0, 1023);
            end
            send_item(ACT_QUERY, VERT_W'(v), col);
        end else if (pick < 95) begin
            v = $urandom_range(0, 1) ? rows_closed + $urandom_range(1, 3)
                                     : $urandom_range(0, 1023);
            send_item($urandom_range(0, 1) ? ACT_ADD : ACT_CLOSE, VERT_W'(v), col);
        end else begin
            counted = 1'b0;
            send_item(ACT_NONE, VERT_W'($urandom_range(0, 1023)), col);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Right after reset both limits are zero, so every row is out of range.
    task automatic test_reset_limits();
        send_item(ACT_QUERY, 10'd0,    10'd0);
        send_item(ACT_ADD,   10'd0,    10'd5);
        send_item(ACT_CLOSE, 10'd1,    10'd0);
        send_item(ACT_NONE,  10'd1023, 10'd1023);
        wait_results_drained();
    endtask

    // Builds three small rows, one of them empty, and queries hits, misses,
    // an unbuilt row and an out-of-range row.
    task automatic test_build_and_query();
        write_config(4, 1024);
        send_item(ACT_ADD,   10'd0,    10'd0);
        send_item(ACT_ADD,   10'd0,    10'd1023);
        send_item(ACT_ADD,   10'd0,    10'd512);
        send_item(ACT_ADD,   10'd1,    10'd7);
        send_item(ACT_CLOSE, 10'd0,    10'd0);
        send_item(ACT_CLOSE, 10'd1,    10'd0);
        send_item(ACT_QUERY, 10'd0,    10'd1023);
        send_item(ACT_QUERY, 10'd0,    10'd6);
        send_item(ACT_QUERY, 10'd1,    10'd0);
        send_item(ACT_QUERY, 10'd2,    10'd0);
        send_item(ACT_QUERY, 10'd1023, 10'd0);
        send_item(ACT_ADD,   10'd2,    10'd341);
        send_item(ACT_ADD,   10'd2,    10'd682);
        send_item(ACT_CLOSE, 10'd2,    10'd0);
        send_item(ACT_QUERY, 10'd2,    10'd682);
        wait_results_drained();
    endtask

    // Row limit equal to the next row, zero columns, then both limits at their top.
    task automatic test_register_limits();
        write_config(3, 0);
        send_item(ACT_ADD,   10'd3,    10'd1);
        send_item(ACT_CLOSE, 10'd3,    10'd0);
        send_item(ACT_QUERY, 10'd0,    10'd0);
        send_item(ACT_QUERY, 10'd5,    10'd1023);
        wait_results_drained();
        write_config(2047, 2047);
        send_item(ACT_QUERY, 10'd0,    10'd1023);
        send_item(ACT_QUERY, 10'd2,    10'd1023);
        send_item(ACT_QUERY, 10'd1023, 10'd1023);
        wait_results_drained();
    endtask

    // Random traffic in several phases, each under its own pair of limits.
    // Now and then the sender pauses until every result is back.
    task automatic test_random_traffic();
        int phase;
        int sent;
        bit counted;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       write_config(1024, 1024);
                1:       write_config(2047, $urandom_range(1, 1023));
                2:       write_config(rows_closed + $urandom_range(1, 3), 2047);
                3:       write_config((rows_closed > 1) ? rows_closed / 2 : 1, 1024);
                default: write_config(rows_closed + 50, $urandom_range(512, 1024));
            endcase
            sent = 0;
            while (sent < 60) begin
                if ($urandom_range(0, 59) == 0)
                    wait_results_drained();
                send_random_item(counted);
                if (counted)
                    sent++;
            end
            wait_results_drained();
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the block fills up and has to stall its input.
    task automatic test_output_hold();
        bit counted;
        write_config(1024, 1024);
        rx_hold_left = 400;
        repeat (16) send_random_item(counted);
        wait_results_drained();
    endtask

    // Builds one long row, then scans it for its first and last entries and for
    // a random column, and closes an empty row after it.
    task automatic test_long_row();
        logic [VERT_W-1:0] row;
        write_config(1024, 1024);
        row = VERT_W'(rows_closed);
        repeat (48)
            send_item(ACT_ADD, row, COL_W'($urandom_range(0, 1023)));
        send_item(ACT_CLOSE, row,        10'd0);
        send_item(ACT_QUERY, row,        column_store[fill_ptr - 1]);
        send_item(ACT_QUERY, row,        column_store[fill_ptr - 48]);
        send_item(ACT_QUERY, row,        COL_W'($urandom_range(0, 1023)));
        send_item(ACT_CLOSE, row + 1'b1, 10'd0);
        send_item(ACT_QUERY, row + 1'b1, 10'd1);
        wait_results_drained();
    endtask

    initial begin : main_sequence
        row_start_tbl[0] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_limits();
        test_build_and_query();
        test_register_limits();
        test_random_traffic();
        test_output_hold();
        test_long_row();
        // Give a late or duplicate result time to show up.
        repeat (40) @(posedge i_clk);
        if (adjacency_answers_due.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("csr_adjacency_build_and_query test passed");
        else
            $display("csr_adjacency_build_and_query test failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/csr_pkg.sv
hdl/csr_ctrl.sv
hdl/csr_dp.sv
hdl/csr_adjacency_build_and_query.sv
test/testbench.sv
